[sv/dqn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dqn_pkg
// shared types and constants of the dns query name extractor
// ----------------------------------------------------------------------------
package dqn_pkg;

    localparam int MAX_NAME_CHARS_DEF = 256;
    localparam int HDR_BYTES          = 12;
    localparam int HDR_POS_W          = 4;
    localparam int NAME_LEN_W         = 9;
    localparam int QDEPTH             = 4;
    localparam int QPTR_W             = 2;
    localparam int QCNT_W             = 3;

    localparam logic [7:0] QCOUNT_HI_POS = 8'd4;
    localparam logic [7:0] QCOUNT_LO_POS = 8'd5;
    localparam logic [7:0] DOT_CHAR      = 8'h2e;
    localparam logic [7:0] TYPE_LAST_LOW = 8'd17;
    localparam logic [7:0] TYPE_AAAA     = 8'd28;
    localparam logic [7:0] TYPE_HTTPS    = 8'd65;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] V_OK           = 3'd0;
    localparam logic [2:0] V_TOO_SHORT    = 3'd1;
    localparam logic [2:0] V_NO_QUESTION  = 3'd2;
    localparam logic [2:0] V_UNTERMINATED = 3'd3;
    localparam logic [2:0] V_TYPE_REJECT  = 3'd4;
    localparam logic [2:0] V_TOO_LONG     = 3'd5;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            name_char;
        logic [2:0]            verdict_code;
        logic [7:0]            query_type_low;
        logic [NAME_LEN_W-1:0] name_length;
    } result_t;

    typedef struct packed {
        logic    char_vld;
        logic    verd_vld;
        result_t char_res;
        result_t verd_res;
    } push_t;

endpackage
`default_nettype wire

[sv/dqn_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dqn_parser
// per-word header skip, label walk and verdict decision
// ----------------------------------------------------------------------------
module dqn_parser
    import dqn_pkg::*;
#(
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] payload_byte,
    input  wire logic       final_byte,
    output push_t           push
);

    localparam int CW = $clog2(MAX_NAME_CHARS + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN,
        PH_DATA,
        PH_TAIL,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next, phase_upd;
    logic [HDR_POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]             left_reg, left_next;
    logic [CW-1:0]          chars_reg, chars_next;
    logic                   qp_reg, qp_next;
    logic                   fld_reg, fld_next;
    logic                   tail_reg, tail_next;
    logic [7:0]             type_reg, type_next;
    logic                   ovf_reg, ovf_next;

    logic                   hdr_short;
    logic                   emit_req;
    logic                   emit;
    logic [7:0]             emit_ch;
    logic [2:0]             code;
    logic                   type_ok;
    logic [CW+NAME_LEN_W-1:0] len_wide;

    always_comb
    begin
        phase_upd  = phase_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        chars_next = chars_reg;
        qp_next    = qp_reg;
        fld_next   = fld_reg;
        tail_next  = tail_reg;
        type_next  = type_reg;
        ovf_next   = ovf_reg;
        hdr_short  = 1'b0;
        emit_req   = 1'b0;
        emit       = 1'b0;
        emit_ch    = payload_byte;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (((8'(pos_reg) == QCOUNT_HI_POS) || (8'(pos_reg) == QCOUNT_LO_POS))
                    && (payload_byte != 8'd0))
                begin
                    qp_next = 1'b1;
                end
                if (pos_reg == HDR_POS_W'(HDR_BYTES - 1))
                begin
                    phase_upd = qp_next ? PH_LEN : PH_DONE;
                end
                else
                begin
                    hdr_short = 1'b1;
                end
                pos_next = pos_reg + HDR_POS_W'(1);
            end
            PH_LEN:
            begin
                if (payload_byte == 8'd0)
                begin
                    phase_upd = PH_TAIL;
                    tail_next = 1'b0;
                end
                else
                begin
                    emit_req  = fld_reg;
                    emit_ch   = DOT_CHAR;
                    fld_next  = 1'b1;
                    left_next = payload_byte;
                    phase_upd = PH_DATA;
                end
            end
            PH_DATA:
            begin
                emit_req  = 1'b1;
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    phase_upd = PH_LEN;
                end
            end
            PH_TAIL:
            begin
                if (tail_reg)
                begin
                    type_next = payload_byte;
                    phase_upd = PH_DONE;
                end
                else
                begin
                    tail_next = 1'b1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (emit_req)
        begin
            if (chars_reg >= CW'(MAX_NAME_CHARS))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                emit       = 1'b1;
                chars_next = chars_reg + CW'(1);
            end
        end

        type_ok = (type_next <= TYPE_LAST_LOW) || (type_next == TYPE_AAAA)
                  || (type_next == TYPE_HTTPS);

        if (hdr_short)
            code = V_TOO_SHORT;
        else if (!qp_next)
            code = V_NO_QUESTION;
        else if (ovf_next)
            code = V_TOO_LONG;
        else if (phase_upd != PH_DONE)
            code = V_UNTERMINATED;
        else if (!type_ok)
            code = V_TYPE_REJECT;
        else
            code = V_OK;

        len_wide = (CW+NAME_LEN_W)'(chars_next);

        push.char_vld                = accept && emit;
        push.char_res.kind           = KIND_CHAR;
        push.char_res.name_char      = emit_ch;
        push.char_res.verdict_code   = V_OK;
        push.char_res.query_type_low = 8'd0;
        push.char_res.name_length    = '0;

        push.verd_vld                = accept && final_byte;
        push.verd_res.kind           = KIND_VERDICT;
        push.verd_res.name_char      = 8'd0;
        push.verd_res.verdict_code   = code;
        push.verd_res.query_type_low = type_next;
        push.verd_res.name_length    = len_wide[NAME_LEN_W-1:0];

        phase_next = phase_upd;
        if (final_byte)
        begin
            phase_next = PH_HEADER;
            pos_next   = '0;
            left_next  = 8'd0;
            chars_next = '0;
            qp_next    = 1'b0;
            fld_next   = 1'b0;
            tail_next  = 1'b0;
            type_next  = 8'd0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            left_reg  <= 8'd0;
            chars_reg <= '0;
            qp_reg    <= 1'b0;
            fld_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            type_reg  <= 8'd0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            chars_reg <= chars_next;
            qp_reg    <= qp_next;
            fld_reg   <= fld_next;
            tail_reg  <= tail_next;
            type_reg  <= type_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    a_chars_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chars_reg <= CW'(MAX_NAME_CHARS))
        else $error("name character count beyond bound");
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (phase_reg == PH_HEADER) && (chars_reg == '0))
        else $error("state not cleared after final word");
    a_char_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.char_vld |-> (chars_reg < CW'(MAX_NAME_CHARS)))
        else $error("character emitted past name bound");
`endif

endmodule
`default_nettype wire

[sv/dqn_result_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dqn_result_queue
// four-entry result queue taking up to two results per cycle
// ----------------------------------------------------------------------------
module dqn_result_queue
    import dqn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    head
);

    result_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [QCNT_W-1:0]   n_push;
    logic                pop;
    result_t             first_res;
    logic [QPTR_W-1:0]   wr_ptr_1;

    assign room      = cnt_reg <= QCNT_W'(QDEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && out_ready;
    assign head      = mem_reg[rd_ptr_reg];
    assign n_push    = QCNT_W'(push.char_vld) + QCNT_W'(push.verd_vld);
    assign first_res = push.char_vld ? push.char_res : push.verd_res;
    assign wr_ptr_1  = wr_ptr_reg + QPTR_W'(1);
    assign cnt_next  = cnt_reg + n_push - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != '0)
        begin
            mem_reg[wr_ptr_reg] <= first_res;
        end
        if (push.char_vld && push.verd_vld)
        begin
            mem_reg[wr_ptr_1] <= push.verd_res;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");
    a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.char_vld && push.verd_vld) |-> (cnt_reg <= QCNT_W'(QDEPTH - 2)))
        else $error("two results pushed without room");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        ((n_push != '0) && !pop) |=> (cnt_reg == $past(cnt_reg) + $past(n_push)))
        else $error("queue fill count lost a push");
`endif

endmodule
`default_nettype wire

[sv/dns_query_name_extractor_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dns_query_name_extractor_top
// extracts the first dns question name as dotted text and gives a verdict
//
// input channel in_valid/in_ready carries one message word (payload_byte,
// final_byte) per handshake, message offset zero first
// output channel out_valid/out_ready carries one result per handshake:
// name characters, then a verdict with end_of_run set on the final word
// each result is registered in the result queue when its word is accepted
// throughput: one word per cycle while in_ready is high; a final word that
// also yields a character produces two results, one per output handshake
// in_ready is high while the four-entry result queue has at least two free slots,
// so a stalled receiver fills the queue and then holds off the sender
// reset clears the parser to the header state and empties the queue;
// after each verdict the parser returns to the header state by itself
// ----------------------------------------------------------------------------
module dns_query_name_extractor_top
    import dqn_pkg::*;
#(
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            payload_byte,
    input  wire logic                  final_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       result_kind,
    output logic [7:0]                 name_char,
    output logic [2:0]                 verdict_code,
    output logic [7:0]                 query_type_low,
    output logic [NAME_LEN_W-1:0]      name_length,
    output logic                       end_of_run
);

    logic    accept;
    push_t   push;
    result_t head;

    assign accept = in_valid && in_ready;

    dqn_parser #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (payload_byte),
        .final_byte   (final_byte),
        .push         (push)
    );

    dqn_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_kind    = head.kind;
    assign name_char      = head.name_char;
    assign verdict_code   = head.verdict_code;
    assign query_type_low = head.query_type_low;
    assign name_length    = head.name_length;
    assign end_of_run     = head.kind;

endmodule
`default_nettype wire
